### rtl/core/tmcw_pkg.sv
// tmcw_pkg: shared types, constants and helpers of the text-mode console writer
// used by tmcw_ctrl, tmcw_dp and text_mode_console_writer_core; no dependencies
package tmcw_pkg;

	localparam int unsigned DEF_COLS   = 80;
	localparam int unsigned DEF_ROWS   = 25;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned DIG_W      = 4;
	localparam int unsigned BCD_W      = NUM_DIGITS * DIG_W;
	localparam int unsigned CONV_STEPS = 32;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] MINUS_CHAR = 8'h2D;
	localparam logic [7:0] RESET_ATTR = 8'h0F;

	// register index of blank_attribute
	localparam logic REG_BLANK_ATTR = 1'b0;

	typedef enum logic [2:0] {
		K_CHAR, K_NEWLINE, K_SDEC, K_UDEC, K_HEX, K_CLEAR, K_READ, K_NONE
	} kind_t;

	typedef enum logic [1:0] {CH_ITEM, CH_MINUS, CH_DIGIT} char_sel_t;

	typedef struct packed {
		logic      load;
		logic      place;
		char_sel_t sel;
		logic      newline;
		logic      conv_step;
		logic      dig_skip;
		logic      scr_step;
		logic      clr_step;
		logic      boot;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		kind_t in_kind;
		logic  place_scr;
		logic  nl_scr;
		logic  conv_last;
		logic  neg;
		logic  dig_lead;
		logic  dig_last;
		logic  dig_pending;
		logic  scr_last;
		logic  clr_last;
		logic  out_free;
	} stat_t;

	// one double-dabble correction over all bcd digits
	function automatic logic [BCD_W-1:0] dd_adjust(input logic [BCD_W-1:0] d);
		logic [BCD_W-1:0] r;
		r = d;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (r[i*DIG_W +: DIG_W] >= 4'd5) r[i*DIG_W +: DIG_W] = r[i*DIG_W +: DIG_W] + 4'd3;
		end
		return r;
	endfunction

	// digit value to upper-case glyph
	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] g;
		if (d < 4'd10) g = 8'h30 + {4'h0, d};
		else g = 8'h37 + {4'h0, d};
		return g;
	endfunction

endpackage

### rtl/core/tmcw_ctrl.sv
// tmcw_ctrl: sequencing state machine of the console writer
// depends on tmcw_pkg; drives commands to tmcw_dp and reads its status
module tmcw_ctrl import tmcw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_CHAR, S_NL, S_CONV, S_SIGN, S_DIG, S_SCRL, S_READ, S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   boot_q;

	always_comb begin
		cmd      = '0;
		cmd.sel  = CH_ITEM;
		state_d  = state_q;
		s_tready = (state_q == S_IDLE);
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				cmd.boot     = boot_q;
				if (stat.clr_last) state_d = boot_q ? S_IDLE : S_DONE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					unique case (stat.in_kind) inside
						K_CHAR:         state_d = S_CHAR;
						K_NEWLINE:      state_d = S_NL;
						K_SDEC, K_UDEC: state_d = S_CONV;
						K_HEX:          state_d = S_DIG;
						K_CLEAR:        state_d = S_CLR;
						K_READ:         state_d = S_READ;
						default:        state_d = S_DONE;
					endcase
				end
			end
			S_CHAR: begin
				cmd.place = 1'b1;
				state_d   = stat.place_scr ? S_SCRL : S_DONE;
			end
			S_NL: begin
				cmd.newline = 1'b1;
				state_d     = stat.nl_scr ? S_SCRL : S_DONE;
			end
			S_CONV: begin
				cmd.conv_step = 1'b1;
				if (stat.conv_last) state_d = stat.neg ? S_SIGN : S_DIG;
			end
			S_SIGN: begin
				cmd.place = 1'b1;
				cmd.sel   = CH_MINUS;
				state_d   = stat.place_scr ? S_SCRL : S_DIG;
			end
			S_DIG: begin
				if (stat.dig_lead) begin
					cmd.dig_skip = 1'b1;
				end else begin
					cmd.place = 1'b1;
					cmd.sel   = CH_DIGIT;
					if (stat.place_scr) state_d = S_SCRL;
					else if (stat.dig_last) state_d = S_DONE;
				end
			end
			S_SCRL: begin
				cmd.scr_step = 1'b1;
				if (stat.scr_last) state_d = stat.dig_pending ? S_DIG : S_DONE;
			end
			S_READ: state_d = S_DONE;
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			boot_q  <= 1'b1;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR && stat.clr_last) boot_q <= 1'b0;
		end
	end

endmodule

### rtl/core/tmcw_dp.sv
// tmcw_dp: cell store, cursor, row ring offset, number converter and result register
// depends on tmcw_pkg; steered by tmcw_ctrl
module tmcw_dp import tmcw_pkg::*; #(
	parameter int unsigned SCREEN_COLS = DEF_COLS,
	parameter int unsigned SCREEN_ROWS = DEF_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic [7:0]  blank_attr,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [39:0] m_tdata,
	output logic        m_tuser
);

	localparam int unsigned CELLS  = SCREEN_COLS * SCREEN_ROWS;
	localparam int unsigned COL_W  = $clog2(SCREEN_COLS);
	localparam int unsigned ROW_W  = $clog2(SCREEN_ROWS);
	localparam int unsigned CELL_W = $clog2(CELLS);
	localparam logic [CELL_W:0]   CELLS_X    = (CELL_W+1)'(CELLS);
	localparam logic [CELL_W-1:0] COLS_C     = CELL_W'(SCREEN_COLS);
	localparam logic [CELL_W-1:0] LAST_START = CELL_W'((SCREEN_ROWS-1) * SCREEN_COLS);
	localparam logic [CELL_W-1:0] LAST_CELL  = CELL_W'(CELLS-1);
	localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(SCREEN_COLS-1);
	localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_ROWS-1);
	localparam logic [3:0]        TOP_DIGIT  = 4'(NUM_DIGITS-1);
	localparam logic [4:0]        CONV_LAST  = 5'(CONV_STEPS-1);

	function automatic logic [CELL_W-1:0] wrap_add(input logic [CELL_W-1:0] a,
			input logic [CELL_W-1:0] b);
		logic [CELL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= CELLS_X) s = s - CELLS_X;
		return s[CELL_W-1:0];
	endfunction

	logic [15:0]       mem [CELLS];
	logic [15:0]       rdata_q;
	kind_t             kind_q;
	logic [7:0]        char_q, color_q;
	logic [10:0]       idx_q;
	logic              neg_q, num_mode_q, started_q, dig_done_q, scrolled_q;
	logic [COL_W-1:0]  col_q, scnt_q;
	logic [ROW_W-1:0]  row_q;
	logic [CELL_W-1:0] lin_q, base_q, sweep_q;
	logic [31:0]       bin_q;
	logic [BCD_W-1:0]  dig_q;
	logic [4:0]        cnt_q;
	logic [3:0]        ptr_q;
	logic [39:0]       out_q;
	logic              out_tuser_q, out_valid_q;

	logic [3:0]        cur_dig;
	logic [7:0]        pchar, battr;
	logic              in_range, we, do_scroll;
	logic [CELL_W-1:0] waddr, raddr;
	logic [15:0]       wdata;
	kind_t             in_kind;
	logic [31:0]       in_num;

	assign in_kind  = kind_t'(s_tuser);
	assign in_num   = s_tdata[39:8];
	assign cur_dig  = dig_q[ptr_q*DIG_W +: DIG_W];
	assign in_range = (32'(idx_q) < CELLS);
	assign raddr    = in_range ? wrap_add(CELL_W'(idx_q), base_q) : '0;
	assign battr    = cmd.boot ? RESET_ATTR : blank_attr;

	always_comb begin
		case (cmd.sel)
			CH_MINUS: pchar = MINUS_CHAR;
			CH_DIGIT: pchar = glyph(cur_dig);
			default:  pchar = char_q;
		endcase
	end

	assign we    = cmd.place | cmd.scr_step | cmd.clr_step;
	assign waddr = cmd.place ? wrap_add(lin_q, base_q) : sweep_q;
	assign wdata = cmd.place ? {color_q, pchar} : {battr, BLANK_CHAR};

	assign do_scroll = (cmd.place && stat.place_scr) || (cmd.newline && stat.nl_scr);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// item fields and converter
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= in_kind;
			char_q  <= s_tdata[7:0];
			color_q <= s_tdata[47:40];
			idx_q   <= s_tdata[58:48];
			bin_q   <= (in_kind == K_SDEC && in_num[31]) ? (32'd0 - in_num) : in_num;
			dig_q   <= (in_kind == K_HEX) ? BCD_W'(in_num) : '0;
			cnt_q   <= '0;
		end else if (cmd.conv_step) begin
			{dig_q, bin_q} <= {dd_adjust(dig_q), bin_q} << 1;
			cnt_q          <= cnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			lin_q       <= '0;
			base_q      <= '0;
			sweep_q     <= '0;
			scnt_q      <= '0;
			neg_q       <= 1'b0;
			num_mode_q  <= 1'b0;
			started_q   <= 1'b0;
			dig_done_q  <= 1'b0;
			scrolled_q  <= 1'b0;
			ptr_q       <= TOP_DIGIT;
			out_valid_q <= 1'b0;
			out_tuser_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cmd.load) begin
				scrolled_q <= 1'b0;
				num_mode_q <= (in_kind inside {K_SDEC, K_UDEC, K_HEX});
				neg_q      <= (in_kind == K_SDEC) && in_num[31];
				ptr_q      <= TOP_DIGIT;
				started_q  <= 1'b0;
				dig_done_q <= 1'b0;
				if (in_kind == K_CLEAR) begin
					col_q   <= '0;
					row_q   <= '0;
					lin_q   <= '0;
					base_q  <= '0;
					sweep_q <= '0;
				end
			end
			if (cmd.dig_skip) ptr_q <= ptr_q - 4'd1;
			if (cmd.place && cmd.sel == CH_DIGIT) begin
				started_q <= 1'b1;
				if (ptr_q == '0) dig_done_q <= 1'b1;
				else ptr_q <= ptr_q - 4'd1;
			end
			if (do_scroll) begin
				// the ring advances one row and the old top row becomes the blank bottom row
				col_q      <= '0;
				row_q      <= LAST_ROW;
				lin_q      <= LAST_START;
				base_q     <= wrap_add(base_q, COLS_C);
				sweep_q    <= base_q;
				scnt_q     <= '0;
				scrolled_q <= 1'b1;
			end else if (cmd.place) begin
				lin_q <= lin_q + 1'b1;
				if (col_q == LAST_COL) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (cmd.newline) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
				lin_q <= lin_q - CELL_W'(col_q) + COLS_C;
			end
			if (cmd.scr_step) begin
				sweep_q <= sweep_q + 1'b1;
				scnt_q  <= scnt_q + 1'b1;
			end
			if (cmd.clr_step) sweep_q <= sweep_q + 1'b1;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				out_tuser_q <= scrolled_q;
				out_q       <= {1'b0,
					(kind_q == K_READ && in_range) ? rdata_q : 16'h0000,
					11'(lin_q), 7'(col_q), 5'(row_q)};
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.in_kind     = in_kind;
		stat.place_scr   = (col_q == LAST_COL) && (row_q == LAST_ROW);
		stat.nl_scr      = (row_q == LAST_ROW);
		stat.conv_last   = (cnt_q == CONV_LAST);
		stat.neg         = neg_q;
		stat.dig_lead    = (cur_dig == 4'd0) && !started_q && (ptr_q != 4'd0);
		stat.dig_last    = (ptr_q == 4'd0);
		stat.dig_pending = num_mode_q && !dig_done_q;
		stat.scr_last    = (scnt_q == LAST_COL);
		stat.clr_last    = (sweep_q == LAST_CELL);
		stat.out_free    = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign m_tuser  = out_tuser_q;

endmodule

### rtl/core/text_mode_console_writer_core.sv
// text_mode_console_writer_core: top level of the text-mode console writer
// depends on tmcw_pkg, tmcw_ctrl and tmcw_dp
//
// One request in, one result out. After reset the block sweeps its whole cell store to blanks
// with attribute 0x0F, one cell a cycle, and takes no request until then; the configuration
// port works throughout. A decimal number runs a bit-serial double-dabble converter, then skips
// leading zeros and places one glyph per digit; hex skips the converter. Every time the cursor
// leaves the bottom row the screen scrolls: the store is a ring of rows, so scrolling only moves
// the ring offset and blanks one row of SCREEN_COLS cells. Clear sweeps the whole store,
// one cell a cycle, as at reset but with blank_attribute. The bit-serial converter and the
// single write port of the cell store keep all of this work serial.
// A request is taken while the previous result still waits in the output register.
module text_mode_console_writer_core import tmcw_pkg::*; #(
	parameter int unsigned SCREEN_COLS = DEF_COLS,
	parameter int unsigned SCREEN_ROWS = DEF_ROWS
) (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // character[7:0], number[39:8], color[47:40], cell_index[58:48]
	input  logic [2:0]  s_tuser,  // kind[2:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // cursor_row_out[4:0], cursor_col_out[11:5],
	                              // cursor_position[22:12], cell_value[38:23]
	output logic        m_tuser,  // scrolled
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [7:0] blank_attr_q;
	cmd_t       cmd;
	stat_t      stat;

	// blank_attribute register, word 0
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_BLANK_ATTR) ? {24'h000000, blank_attr_q} : 32'h00000000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_attr_q <= RESET_ATTR;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_BLANK_ATTR) begin
			blank_attr_q <= pwdata[7:0];
		end
	end

	// sequencer
	tmcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// store, cursor, converter and result register
	tmcw_dp #(
		.SCREEN_COLS (SCREEN_COLS),
		.SCREEN_ROWS (SCREEN_ROWS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.cmd        (cmd),
		.stat       (stat),
		.blank_attr (blank_attr_q),
		.m_tready   (m_tready),
		.m_tvalid   (m_tvalid),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

	// the store has a single write port
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.place, cmd.scr_step, cmd.clr_step}))
		else $error("cell store written by two sources");

	// one request at a time
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while busy");

	// a scroll always leaves the cursor on the last row
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[4:0] == 5'(SCREEN_ROWS-1)))
		else $error("scrolled result off the last row");

	// a new result is only loaded when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result overwritten");

endmodule
